>>> rtl/mhft_pkg.sv
// ----------------------------------------------------------------------------
// mhft_pkg: shared types and constants for the multicast hash filter table
// Group list sizing, CRC-32 byte step, entry and cell control types, codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mhft_pkg;

  localparam int MAX_GROUPS = 32;
  localparam int MAC_W      = 48;
  localparam int HASH_W     = 32;
  localparam int TABLE_W    = 64;
  localparam int GCOUNT_W   = 6;
  localparam int BUCKET_W   = 6;
  localparam int BYTES      = MAC_W / 8;
  localparam int COUNT_W    = $clog2(MAX_GROUPS + 1);
  localparam int IDX_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int BYTE_IDX_W = $clog2(BYTES);

  localparam logic [HASH_W-1:0] CRC_INIT = 32'hffff_ffff;
  localparam logic [HASH_W-1:0] CRC_POLY = 32'h04c1_1db7;

  localparam logic OP_JOIN  = 1'b0;
  localparam logic OP_LEAVE = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_LISTED   = 2'd1,
    STAT_UNLISTED = 2'd2,
    STAT_FULL     = 2'd3
  } result_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CRC,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              tent;
    logic [HASH_W-1:0] hash;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic commit;
    logic cancel;
  } cell_ctrl_t;

  function automatic logic [HASH_W-1:0] crc_byte(input logic [HASH_W-1:0] crc_in,
                                                 input logic [7:0] octet);
    logic [HASH_W-1:0] crc;
    logic              fb;
    crc = crc_in;
    for (int b = 0; b < 8; b++) begin
      fb  = crc[HASH_W-1] ^ octet[b];
      crc = {crc[HASH_W-2:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic logic [TABLE_W-1:0] bucket_bit(input logic [HASH_W-1:0] hash);
    return TABLE_W'(1) << hash[HASH_W-1 -: BUCKET_W];
  endfunction

endpackage

`default_nettype wire

>>> rtl/mhft_crc.sv
// ----------------------------------------------------------------------------
// mhft_crc: byte-serial Ethernet CRC-32 of a group address
// One address byte per cycle, preset all ones, no final inversion.
// ----------------------------------------------------------------------------
`default_nettype none

module mhft_crc
  import mhft_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [MAC_W-1:0]  mac_address,
  output logic                   done,
  output logic [HASH_W-1:0]      hash
);

  logic [MAC_W-1:0]      mac_sr;
  logic [BYTE_IDX_W-1:0] byte_cnt;
  logic                  busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      byte_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        byte_cnt <= '0;
      end else if (busy) begin
        byte_cnt <= byte_cnt + BYTE_IDX_W'(1);
        if (byte_cnt == BYTE_IDX_W'(BYTES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mac_sr <= mac_address;
      hash   <= CRC_INIT;
    end else if (busy) begin
      mac_sr <= mac_sr >> 8;
      hash   <= crc_byte(hash, mac_sr[7:0]);
    end
  end

endmodule

`default_nettype wire

>>> rtl/mhft_cell.sv
// ----------------------------------------------------------------------------
// mhft_cell: one slot of the rotating group list
// Takes its neighbor's entry on shift; settles a tentative insert on commit.
// ----------------------------------------------------------------------------
`default_nettype none

module mhft_cell
  import mhft_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire entry_t     din,
  output entry_t          dout
);

  logic              valid;
  logic              tent;
  logic [HASH_W-1:0] hash;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      tent  <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= din.valid;
      tent  <= din.tent;
    end else if (ctrl.commit) begin
      if (ctrl.cancel && tent) begin
        valid <= 1'b0;
      end
      tent <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      hash <= din.hash;
    end
  end

  assign dout = '{valid: valid, tent: tent, hash: hash};

endmodule

`default_nettype wire

>>> rtl/multicast_hash_filter_table.sv
// ----------------------------------------------------------------------------
// multicast_hash_filter_table: join/leave list of CRC-32 group hashes
// Each accepted beat passes byte-serial CRC, a hand-off, a full rotation of the
// MAX_GROUPS (32) cell ring and a commit before its result beat is presented.
// One request is handled at a time: the next is accepted only after the commit;
// a result beat not yet taken holds the commit of the next request.
// Reset empties the list (occupancy bits cleared); stored hashes are undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module multicast_hash_filter_table
  import mhft_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // mac_address[47:0]
  input  wire logic [0:0]  s_tuser,   // op[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // hash_table[63:0], multicast_enable[64],
                                      // group_count[70:65], zero[71]
  output logic [1:0]       m_tuser    // status[1:0]
);

  state_t             state, state_next;
  logic               op;
  logic               found;
  logic               inserted;
  logic [IDX_W-1:0]   scan_cnt;
  logic [COUNT_W-1:0] count;
  logic [TABLE_W-1:0] table_acc;

  logic               crc_done;
  logic [HASH_W-1:0]  hash;

  cell_ctrl_t         ctrl;
  entry_t             cell_out [MAX_GROUPS];
  entry_t             head_in, head_out;
  logic               hit, drop, ins;
  logic               out_free;
  logic               accept;

  result_code_t       status_next;
  logic [COUNT_W-1:0] count_next;
  logic [TABLE_W-1:0] table_next;

  logic [MAX_GROUPS-1:0] valid_vec;

  logic [TABLE_W-1:0]  out_table;
  logic [GCOUNT_W-1:0] out_count;
  result_code_t        out_status;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  mhft_crc u_crc (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .mac_address (s_tdata[MAC_W-1:0]),
    .done        (crc_done),
    .hash        (hash)
  );

  for (genvar i = 0; i < MAX_GROUPS; i++) begin : g_cell
    entry_t cell_in;
    if (i == 0) begin : g_head
      assign cell_in = head_out;
    end else begin : g_link
      assign cell_in = cell_out[i-1];
    end
    mhft_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .din  (cell_in),
      .dout (cell_out[i])
    );
    assign valid_vec[i] = cell_out[i].valid;
  end

  always_comb begin
    head_in  = cell_out[MAX_GROUPS-1];
    head_out = head_in;
    hit      = head_in.valid && !head_in.tent && (head_in.hash == hash);
    drop     = hit && (op == OP_LEAVE);
    ins      = !head_in.valid && (op == OP_JOIN) && !inserted &&
               (count < COUNT_W'(MAX_GROUPS));
    if (drop) begin
      head_out.valid = 1'b0;
    end
    if (ins) begin
      head_out = '{valid: 1'b1, tent: 1'b1, hash: hash};
    end
  end

  always_comb begin
    status_next = STAT_DONE;
    count_next  = count;
    table_next  = table_acc;
    if (op == OP_JOIN) begin
      if (found) begin
        status_next = STAT_LISTED;
      end else if (count >= COUNT_W'(MAX_GROUPS)) begin
        status_next = STAT_FULL;
      end else begin
        count_next = count + COUNT_W'(1);
        table_next = table_acc | bucket_bit(hash);
      end
    end else begin
      if (found) begin
        count_next = count - COUNT_W'(1);
      end else begin
        status_next = STAT_UNLISTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    ctrl.shift  = 1'b0;
    ctrl.commit = 1'b0;
    ctrl.cancel = (op == OP_JOIN) && found;
    case (state)
      ST_IDLE: begin
        s_tready = !rst;
        if (s_tvalid) begin
          state_next = ST_CRC;
        end
      end
      ST_CRC: begin
        if (crc_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctrl.shift = 1'b1;
        if (scan_cnt == IDX_W'(MAX_GROUPS - 1)) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          ctrl.commit = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ctrl.commit) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= s_tuser[0];
      found     <= 1'b0;
      inserted  <= 1'b0;
      scan_cnt  <= '0;
      table_acc <= '0;
    end else if (ctrl.shift) begin
      scan_cnt <= scan_cnt + IDX_W'(1);
      found    <= found | hit;
      inserted <= inserted | ins;
      if (head_in.valid && !head_in.tent && !drop) begin
        table_acc <= table_acc | bucket_bit(head_in.hash);
      end
    end
    if (ctrl.commit) begin
      out_status <= status_next;
      out_table  <= table_next;
      out_count  <= GCOUNT_W'(count_next);
    end
  end

  assign m_tdata = {1'b0, out_count, (out_count != '0), out_table};
  assign m_tuser = out_status;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(MAX_GROUPS))
    else $error("group count above list size");

  a_ring_matches_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ($countones(valid_vec) == int'(count)))
    else $error("occupied cells disagree with group count");

  a_enable_vs_table: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[64] == 1'b0) == (m_tdata[63:0] == '0)))
    else $error("enable flag disagrees with filter table");
`endif

endmodule

`default_nettype wire

>>> bench/multicast_hash_filter_table_tb.sv
// ----------------------------------------------------------------------------
// multicast_hash_filter_table_tb: join/leave stream check of the hash filter
// Drives join and leave beats for 48-bit group addresses and checks every
// result beat against a local CRC-32 group list: status, filter bitmap,
// enable flag and group count. A short table covers the corner cases, then
// random traffic fills and drains the list under random and long stalls.
// ----------------------------------------------------------------------------
module multicast_hash_filter_table_tb
  import mhft_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1150;
  localparam int POOL         = 48;
  localparam int HOLD_CYCLES  = 500;
  localparam int LIMIT_CYCLES = 600000;
  localparam logic [31:0] HASH_SEED = 32'hffff_ffff;
  localparam logic [31:0] HASH_POLY = 32'h04c1_1db7;

  typedef struct packed {
    result_code_t status;
    logic [63:0]  bitmap;
    logic         enable;
    logic [5:0]   count;
  } result_t;

  typedef struct packed {
    logic         op;
    logic [47:0]  mac;
    logic         twin;
    logic         typed;
    result_t      fixed;
  } step_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;   // mac_address[47:0]
  logic [0:0]   s_tuser = '0;   // op[0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;        // hash_table[63:0], multicast_enable[64],
                                // group_count[70:65], zero[71]
  logic [1:0]   m_tuser;        // status[1:0]

  logic [31:0]  joined_hashes[$];
  result_t      due_results[$];
  result_t      want;
  logic [47:0]  pool [POOL];
  logic [47:0]  twin_mask;
  step_row_t    plan [0:17];
  int           mismatches = 0;
  int           cycles = 0;
  int           hold_asked = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  bit           calm = 1'b0;

  multicast_hash_filter_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] group_hash(input logic [47:0] mac);
    logic [31:0] r;
    logic        fb;
    r = HASH_SEED;
    for (int k = 0; k < 48; k++) begin
      fb = r[31] ^ mac[k];
      r  = {r[30:0], 1'b0};
      if (fb) begin
        r = r ^ HASH_POLY;
      end
    end
    return r;
  endfunction

  // XOR with the generator polynomial placed in the bit stream leaves the CRC unchanged
  function automatic logic [47:0] collision_mask();
    logic [47:0] m;
    m = '0;
    m[15] = 1'b1;
    for (int i = 0; i < 32; i++) begin
      if (HASH_POLY[i]) begin
        m[47-i] = 1'b1;
      end
    end
    return m;
  endfunction

  function automatic logic [47:0] random_group();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic result_t apply_request(input logic op, input logic [47:0] mac);
    logic [31:0] h;
    int          slot;
    result_t     r;
    h = group_hash(mac);
    slot = -1;
    foreach (joined_hashes[i]) begin
      if (slot < 0 && joined_hashes[i] == h) begin
        slot = i;
      end
    end
    r.status = STAT_DONE;
    if (op == OP_JOIN) begin
      if (slot >= 0) begin
        r.status = STAT_LISTED;
      end else if (joined_hashes.size() >= MAX_GROUPS) begin
        r.status = STAT_FULL;
      end else begin
        joined_hashes.push_back(h);
      end
    end else if (slot < 0) begin
      r.status = STAT_UNLISTED;
    end else begin
      joined_hashes[slot] = joined_hashes[$];
      void'(joined_hashes.pop_back());
    end
    r.bitmap = '0;
    foreach (joined_hashes[i]) begin
      r.bitmap[joined_hashes[i][31:26]] = 1'b1;
    end
    r.enable = (joined_hashes.size() != 0);
    r.count  = 6'(joined_hashes.size());
    return r;
  endfunction

  task automatic offer(input logic op, input logic [47:0] mac, input logic typed,
                       input result_t fixed);
    result_t r;
    s_tvalid <= 1'b1;
    s_tdata  <= mac;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    r = apply_request(op, mac);
    due_results.push_back(typed ? fixed : r);
    if (!calm && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic await_drain();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic note_field(input string what, input logic [63:0] exp_v,
                            input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $display("%0t ns: %s expected %h actual %h", $time, what, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result beat with none expected, actual %h %h",
                 $time, m_tuser, m_tdata);
      end else begin
        want = due_results.pop_front();
        note_field("status", 64'(want.status), 64'(m_tuser));
        note_field("hash_table", want.bitmap, m_tdata[63:0]);
        note_field("multicast_enable", 64'(want.enable), 64'(m_tdata[64]));
        note_field("group_count", 64'(want.count), 64'(m_tdata[70:65]));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [47:0] mac;
    logic        op;
    int          pick;
    int          join_pct;
    result_t     none;
    none = '{STAT_DONE, 64'h0, 1'b0, 6'd0};
    twin_mask = collision_mask();
    plan = '{
      '{OP_LEAVE, 48'h0000_0000_0000, 1'b0, 1'b1, '{STAT_UNLISTED, 64'h0, 1'b0, 6'd0}},
      '{OP_JOIN,  48'h0000_0000_0000, 1'b0, 1'b0, none},
      '{OP_JOIN,  48'h0000_0000_0000, 1'b0, 1'b0, none},
      '{OP_JOIN,  48'h0000_0000_0000, 1'b1, 1'b0, none},
      '{OP_JOIN,  48'hffff_ffff_ffff, 1'b0, 1'b0, none},
      '{OP_JOIN,  48'h0100_005e_0001, 1'b0, 1'b0, none},
      '{OP_JOIN,  48'h5555_5555_5555, 1'b0, 1'b0, none},
      '{OP_JOIN,  48'haaaa_aaaa_aaaa, 1'b0, 1'b0, none},
      '{OP_LEAVE, 48'h0000_0000_0000, 1'b1, 1'b0, none},
      '{OP_LEAVE, 48'h0000_0000_0000, 1'b0, 1'b0, none},
      '{OP_LEAVE, 48'h1234_5678_9abc, 1'b0, 1'b0, none},
      '{OP_LEAVE, 48'hffff_ffff_ffff, 1'b0, 1'b0, none},
      '{OP_LEAVE, 48'h0100_005e_0001, 1'b0, 1'b0, none},
      '{OP_LEAVE, 48'h5555_5555_5555, 1'b0, 1'b0, none},
      '{OP_LEAVE, 48'haaaa_aaaa_aaaa, 1'b0, 1'b1, '{STAT_DONE, 64'h0, 1'b0, 6'd0}},
      '{OP_LEAVE, 48'haaaa_aaaa_aaaa, 1'b0, 1'b1, '{STAT_UNLISTED, 64'h0, 1'b0, 6'd0}},
      '{OP_JOIN,  48'h8000_0000_0001, 1'b0, 1'b0, none},
      '{OP_LEAVE, 48'h8000_0000_0001, 1'b0, 1'b1, '{STAT_DONE, 64'h0, 1'b0, 6'd0}}
    };
    foreach (pool[i]) begin
      pool[i] = random_group();
    end
    join_pct = 25;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      offer(plan[i].op, plan[i].mac ^ (plan[i].twin ? twin_mask : 48'h0),
            plan[i].typed, plan[i].fixed);
    end
    await_drain();

    // alternate join-heavy and leave-heavy phases to fill and empty the list
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 300 && n < 500);
      if (n % 64 == 0) begin
        join_pct = (join_pct > 50) ? 25 : 85;
      end
      if (n == 700) begin
        hold_asked++;
      end
      if (n == 900) begin
        await_drain();
      end
      op = ($urandom_range(99) < join_pct) ? OP_JOIN : OP_LEAVE;
      pick = $urandom_range(99);
      if (pick < 80) begin
        mac = pool[$urandom_range(POOL-1)];
      end else if (pick < 88) begin
        mac = pool[$urandom_range(POOL-1)] ^ twin_mask;
      end else begin
        mac = random_group();
      end
      if ($urandom_range(99) < 5) begin
        pool[$urandom_range(POOL-1)] = random_group();
      end
      offer(op, mac, 1'b0, none);
    end
    calm = 1'b0;

    await_drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
